// ===== sv/asof_pkg.sv =====
package asof_pkg;

    // result field widths
    localparam int OFFSET_W = 30;
    localparam int KIND_W   = 3;

    // start kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_RAW   = 3'd0,
        KIND_ID3V2 = 3'd1,
        KIND_TAG   = 3'd2,
        KIND_RIFF  = 3'd3,
        KIND_SYNC  = 3'd4
    } kind_t;

    // byte values and four-byte markers
    localparam logic [7:0]  BYTE_SYNC    = 8'hFF;
    localparam logic [7:0]  BYTE_FB      = 8'hFB;
    localparam logic [7:0]  BYTE_F3      = 8'hF3;
    localparam logic [7:0]  FOOTER_MASK  = 8'h10;
    localparam logic [7:0]  CHAR_I       = 8'h49;
    localparam logic [7:0]  CHAR_D       = 8'h44;
    localparam logic [7:0]  CHAR_3       = 8'h33;
    localparam logic [7:0]  CHAR_T       = 8'h54;
    localparam logic [7:0]  CHAR_A       = 8'h41;
    localparam logic [7:0]  CHAR_G       = 8'h47;
    localparam logic [31:0] WORD_RIFF    = 32'h52494646;
    localparam logic [31:0] WORD_DATA    = 32'h64617461;

    // fixed lengths and offsets
    localparam logic [OFFSET_W-1:0] HDR_LEN     = 30'd10;
    localparam logic [OFFSET_W-1:0] TAG_OFFSET  = 30'd128;
    localparam logic [OFFSET_W-1:0] DATA_SKIP   = 30'd8;

endpackage

// ===== sv/audio_start_offset_finder.sv =====
// the accepted last byte passes the input register, then the result register, to out_valid
// throughput: one byte per cycle; bytes are taken while a finished result waits,
// only a last byte stalls when the result register is still full
// each byte is compared and its positions latched into the scan state from the input register
// reset (rst_n low, asynchronous) clears all scan state and both valid flags;
// scan state also returns to its reset values after every result
module audio_start_offset_finder
    import asof_pkg::*;
#(
    parameter int SCAN_LIMIT = 32768
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OFFSET_W-1:0] start_offset,
    output logic [KIND_W-1:0]   start_kind,
    output logic                header_error
);

    localparam int POS_W = $clog2(SCAN_LIMIT + 1);
    localparam logic [POS_W-1:0]    LIMIT_P = POS_W'(SCAN_LIMIT);
    localparam logic [OFFSET_W-1:0] LIMIT_O = OFFSET_W'(SCAN_LIMIT);

    // input register
    logic             s_valid_reg, s_valid_next;
    logic [7:0]       s_byte_reg;
    logic             s_last_reg;

    // scan state
    logic [POS_W-1:0]    pos_reg, pos_next, pos_upd;
    logic [31:0]         recent_reg, recent_next, recent_upd;
    logic [OFFSET_W-1:0] hdr_reg, hdr_next, hdr_upd;
    logic                id3_reg, id3_next, id3_upd;
    logic                tag_reg, tag_next, tag_upd;
    logic                ff0_reg, ff0_next, ff0_upd;
    logic                hff_reg, hff_next, hff_upd;
    logic                riff_reg, riff_next, riff_upd;
    logic [POS_W-1:0]    riff_pos_reg, riff_pos_next, riff_pos_upd;
    logic [POS_W-1:0]    data_pos_reg, data_pos_next, data_pos_upd;
    logic [POS_W-1:0]    sync_pos_reg, sync_pos_next, sync_pos_upd;
    logic [POS_W-1:0]    id3_sync_reg, id3_sync_next, id3_sync_upd;

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                err_reg, err_next;

    logic out_free;
    logic proc_fire;
    logic fire_last;
    logic take;

    // handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = s_valid_reg && (!s_last_reg || out_free);
    assign fire_last = proc_fire && s_last_reg;
    assign in_stall  = s_valid_reg && !proc_fire;
    assign take      = pos_reg < LIMIT_P;

    assign s_valid_next = in_valid ? 1'b1 : (proc_fire ? 1'b0 : s_valid_reg);

    // state after taking the staged byte
    always_comb
    begin
        logic [7:0]       b;
        logic [15:0]      low16;
        logic [POS_W-1:0] pm1;
        b            = s_byte_reg;
        pm1          = pos_reg - POS_W'(1);
        recent_upd   = recent_reg;
        pos_upd      = pos_reg;
        hdr_upd      = hdr_reg;
        id3_upd      = id3_reg;
        tag_upd      = tag_reg;
        ff0_upd      = ff0_reg;
        hff_upd      = hff_reg;
        riff_upd     = riff_reg;
        riff_pos_upd = riff_pos_reg;
        data_pos_upd = data_pos_reg;
        sync_pos_upd = sync_pos_reg;
        id3_sync_upd = id3_sync_reg;
        low16        = {recent_reg[7:0], b};
        if (take)
        begin
            recent_upd = {recent_reg[23:0], b};
            pos_upd    = pos_reg + POS_W'(1);
            // prefix marks and id3 size word
            if (pos_reg == POS_W'(0))
            begin
                id3_upd = (b == CHAR_I);
                tag_upd = (b == CHAR_T);
                ff0_upd = (b == BYTE_SYNC);
            end
            else if (pos_reg == POS_W'(1))
            begin
                id3_upd = id3_reg && (b == CHAR_D);
                tag_upd = tag_reg && (b == CHAR_A);
            end
            else if (pos_reg == POS_W'(2))
            begin
                id3_upd = id3_reg && (b == CHAR_3);
                tag_upd = tag_reg && (b == CHAR_G);
            end
            else if (pos_reg == POS_W'(5))
            begin
                hdr_upd = ((b & FOOTER_MASK) != 8'h00) ? HDR_LEN : '0;
            end
            else if (pos_reg == POS_W'(6))
            begin
                hdr_upd = hdr_reg + {1'b0, b, 21'd0};
            end
            else if (pos_reg == POS_W'(7))
            begin
                hdr_upd = hdr_reg + {8'd0, b, 14'd0};
            end
            else if (pos_reg == POS_W'(8))
            begin
                hdr_upd = hdr_reg + {15'd0, b, 7'd0};
            end
            else if (pos_reg == POS_W'(9))
            begin
                hdr_upd = hdr_reg + {22'd0, b} + HDR_LEN;
            end
            // sync after the id3 header
            if (pos_reg >= POS_W'(10) && id3_reg)
            begin
                if (hdr_reg == OFFSET_W'(pos_reg) && b == BYTE_SYNC)
                    hff_upd = 1'b1;
                if (id3_sync_reg == '0 && OFFSET_W'(pm1) > hdr_reg
                    && low16 == {BYTE_SYNC, BYTE_FB})
                    id3_sync_upd = pm1;
            end
            // first frame sync past the first byte
            if (pos_reg >= POS_W'(2) && sync_pos_reg == '0
                && (low16 == {BYTE_SYNC, BYTE_FB} || low16 == {BYTE_SYNC, BYTE_F3}))
                sync_pos_upd = pm1;
            // riff and data chunk markers
            if (pos_reg >= POS_W'(3))
            begin
                if (!riff_reg)
                begin
                    if ({recent_reg[23:0], b} == WORD_RIFF)
                    begin
                        riff_upd     = 1'b1;
                        riff_pos_upd = pos_reg - POS_W'(3);
                    end
                end
                else if (data_pos_reg == '0 && {recent_reg[23:0], b} == WORD_DATA)
                begin
                    data_pos_upd = pos_reg - POS_W'(3);
                end
            end
        end
    end

    // rule selection on the finished scan
    always_comb
    begin
        logic                long_scan;
        logic [OFFSET_W-1:0] n;
        n           = OFFSET_W'(pos_upd);
        long_scan   = pos_upd > POS_W'(10);
        offset_next = '0;
        kind_next   = KIND_RAW;
        err_next    = 1'b0;
        priority if (long_scan && id3_upd)
        begin
            kind_next = KIND_ID3V2;
            if (hdr_upd > LIMIT_O || hff_upd)
                offset_next = hdr_upd;
            else if (id3_sync_upd != '0)
                offset_next = OFFSET_W'(id3_sync_upd);
            else
                offset_next = (hdr_upd >= n) ? hdr_upd : n;
        end
        else if (long_scan && tag_upd)
        begin
            kind_next   = KIND_TAG;
            offset_next = TAG_OFFSET;
        end
        else if (long_scan && riff_upd && riff_pos_upd < pos_upd - POS_W'(10))
        begin
            kind_next = KIND_RIFF;
            if (data_pos_upd != '0)
                offset_next = OFFSET_W'(data_pos_upd) + DATA_SKIP;
            else
                err_next = 1'b1;
        end
        else if (!ff0_upd && sync_pos_upd != '0)
        begin
            kind_next   = KIND_SYNC;
            offset_next = OFFSET_W'(sync_pos_upd);
        end
        else
        begin
            kind_next = KIND_RAW;
        end
    end

    // state advance, cleared after each result
    always_comb
    begin
        pos_next      = pos_reg;
        recent_next   = recent_reg;
        hdr_next      = hdr_reg;
        id3_next      = id3_reg;
        tag_next      = tag_reg;
        ff0_next      = ff0_reg;
        hff_next      = hff_reg;
        riff_next     = riff_reg;
        riff_pos_next = riff_pos_reg;
        data_pos_next = data_pos_reg;
        sync_pos_next = sync_pos_reg;
        id3_sync_next = id3_sync_reg;
        if (fire_last)
        begin
            pos_next      = '0;
            recent_next   = '0;
            hdr_next      = '0;
            id3_next      = 1'b0;
            tag_next      = 1'b0;
            ff0_next      = 1'b0;
            hff_next      = 1'b0;
            riff_next     = 1'b0;
            riff_pos_next = '0;
            data_pos_next = '0;
            sync_pos_next = '0;
            id3_sync_next = '0;
        end
        else if (proc_fire)
        begin
            pos_next      = pos_upd;
            recent_next   = recent_upd;
            hdr_next      = hdr_upd;
            id3_next      = id3_upd;
            tag_next      = tag_upd;
            ff0_next      = ff0_upd;
            hff_next      = hff_upd;
            riff_next     = riff_upd;
            riff_pos_next = riff_pos_upd;
            data_pos_next = data_pos_upd;
            sync_pos_next = sync_pos_upd;
            id3_sync_next = id3_sync_upd;
        end
    end

    // result valid
    always_comb
    begin
        if (fire_last)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            recent_reg    <= '0;
            hdr_reg       <= '0;
            id3_reg       <= 1'b0;
            tag_reg       <= 1'b0;
            ff0_reg       <= 1'b0;
            hff_reg       <= 1'b0;
            riff_reg      <= 1'b0;
            riff_pos_reg  <= '0;
            data_pos_reg  <= '0;
            sync_pos_reg  <= '0;
            id3_sync_reg  <= '0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            recent_reg    <= recent_next;
            hdr_reg       <= hdr_next;
            id3_reg       <= id3_next;
            tag_reg       <= tag_next;
            ff0_reg       <= ff0_next;
            hff_reg       <= hff_next;
            riff_reg      <= riff_next;
            riff_pos_reg  <= riff_pos_next;
            data_pos_reg  <= data_pos_next;
            sync_pos_reg  <= sync_pos_next;
            id3_sync_reg  <= id3_sync_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s_byte_reg <= data_byte;
            s_last_reg <= last_byte;
        end
        if (fire_last)
        begin
            offset_reg <= offset_next;
            kind_reg   <= kind_next;
            err_reg    <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign start_offset = offset_reg;
    assign start_kind   = kind_reg;
    assign header_error = err_reg;

    // a finished scan always produces a result
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire_last |=> out_valid_reg)
        else $error("last byte did not produce a result");

    // scan state starts over after a result
    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire_last |=> (pos_reg == '0 && !riff_reg && sync_pos_reg == '0))
        else $error("scan state not cleared after result");

    // byte count saturates at the scan limit
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LIMIT_P)
        else $error("byte position beyond scan limit");

    // header error only comes with a riff result
    a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> kind_reg == KIND_RIFF)
        else $error("header error without riff kind");

    // sync at the id3 offset only tracked for id3 scans
    a_hff_needs_id3: assert property (@(posedge clk) disable iff (!rst_n)
        hff_reg |-> id3_reg)
        else $error("id3 offset sync flag without id3 prefix");

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asof_pkg::*;

    localparam int SCAN_LIMIT   = 64;
    localparam int MAXB         = 32;
    localparam int RAND_ITEMS   = 900;
    localparam int CALM_ITEMS   = 760;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_SCANS   = 40;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [OFFSET_W-1:0] offset;
        kind_t               kind;
        logic                err;
    } start_rec_t;

    // one directed scan, first byte in the most significant used lane
    typedef struct {
        int                len;
        logic [8*MAXB-1:0] bytes;
        bit                typed;
        start_rec_t        want;
    } scan_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          data_byte;
    logic                last_byte;
    logic                out_valid;
    logic                out_stall;
    logic [OFFSET_W-1:0] start_offset;
    logic [KIND_W-1:0]   start_kind;
    logic                header_error;

    start_rec_t pending_starts [$];
    logic [7:0] scan_bytes [$];
    int         fails;
    int         random_items;
    int         hold_req;
    int         hold_done;
    bit         calm;

    // scan tracker state
    logic [15:0]         trk_pos;
    logic [31:0]         trk_recent;
    logic [OFFSET_W-1:0] trk_hdr;
    logic                trk_id3;
    logic                trk_tag;
    logic                trk_ff0;
    logic                trk_hdr_ff;
    logic                trk_riff;
    logic [15:0]         trk_riff_pos;
    logic [15:0]         trk_data_pos;
    logic [15:0]         trk_first_sync;
    logic [15:0]         trk_id3_sync;

    audio_start_offset_finder #(.SCAN_LIMIT(SCAN_LIMIT)) uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .start_offset (start_offset),
        .start_kind   (start_kind),
        .header_error (header_error)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic clear_scan_tracker();
        trk_pos        = '0;
        trk_recent     = '0;
        trk_hdr        = '0;
        trk_id3        = 1'b0;
        trk_tag        = 1'b0;
        trk_ff0        = 1'b0;
        trk_hdr_ff     = 1'b0;
        trk_riff       = 1'b0;
        trk_riff_pos   = '0;
        trk_data_pos   = '0;
        trk_first_sync = '0;
        trk_id3_sync   = '0;
    endtask

    // follow one accepted byte, queue the start offset on the last one
    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [15:0] p;
        logic [15:0] n;
        start_rec_t  r;
        if (trk_pos < SCAN_LIMIT)
        begin
            p = trk_pos;
            trk_recent = {trk_recent[23:0], b};
            // tag signatures and id3v2 size word
            if (p == 0)
            begin
                if (b == CHAR_I) trk_id3 = 1'b1;
                if (b == CHAR_T) trk_tag = 1'b1;
                if (b == BYTE_SYNC) trk_ff0 = 1'b1;
            end
            else if (p == 1)
            begin
                if (b != CHAR_D) trk_id3 = 1'b0;
                if (b != CHAR_A) trk_tag = 1'b0;
            end
            else if (p == 2)
            begin
                if (b != CHAR_3) trk_id3 = 1'b0;
                if (b != CHAR_G) trk_tag = 1'b0;
            end
            else if (p == 5)
            begin
                trk_hdr = ((b & FOOTER_MASK) != 0) ? HDR_LEN : '0;
            end
            else if (p >= 6 && p <= 9)
            begin
                trk_hdr = trk_hdr + (30'(b) << (7 * (9 - p)));
                if (p == 9) trk_hdr = trk_hdr + HDR_LEN;
            end
            // frame sync right at or beyond the id3v2 offset
            if (p >= 10 && trk_id3)
            begin
                if (trk_hdr == 30'(p) && b == BYTE_SYNC) trk_hdr_ff = 1'b1;
                if (trk_id3_sync == 0 && (p - 16'd1) > trk_hdr
                    && trk_recent[15:0] == {BYTE_SYNC, BYTE_FB})
                    trk_id3_sync = p - 16'd1;
            end
            // first plain frame sync
            if (p >= 2 && trk_first_sync == 0
                && (trk_recent[15:0] == {BYTE_SYNC, BYTE_FB}
                    || trk_recent[15:0] == {BYTE_SYNC, BYTE_F3}))
                trk_first_sync = p - 16'd1;
            // riff header and the data chunk after it
            if (p >= 3)
            begin
                if (!trk_riff)
                begin
                    if (trk_recent == WORD_RIFF)
                    begin
                        trk_riff     = 1'b1;
                        trk_riff_pos = p - 16'd3;
                    end
                end
                else if (trk_data_pos == 0 && trk_recent == WORD_DATA)
                begin
                    trk_data_pos = p - 16'd3;
                end
            end
            trk_pos = p + 16'd1;
        end
        if (last)
        begin
            n        = trk_pos;
            r.offset = '0;
            r.kind   = KIND_RAW;
            r.err    = 1'b0;
            // rules in priority order
            if (n > HDR_LEN && trk_id3)
            begin
                r.kind = KIND_ID3V2;
                if (trk_hdr > SCAN_LIMIT || trk_hdr_ff)
                    r.offset = trk_hdr;
                else if (trk_id3_sync != 0)
                    r.offset = 30'(trk_id3_sync);
                else
                    r.offset = (trk_hdr >= 30'(n)) ? trk_hdr : 30'(n);
            end
            else if (n > HDR_LEN && trk_tag)
            begin
                r.kind   = KIND_TAG;
                r.offset = TAG_OFFSET;
            end
            else if (n > HDR_LEN && trk_riff && trk_riff_pos < n - 16'd10)
            begin
                r.kind = KIND_RIFF;
                if (trk_data_pos != 0)
                    r.offset = 30'(trk_data_pos) + DATA_SKIP;
                else
                    r.err = 1'b1;
            end
            else if (!trk_ff0 && trk_first_sync != 0)
            begin
                r.kind   = KIND_SYNC;
                r.offset = 30'(trk_first_sync);
            end
            pending_starts.push_back(r);
            clear_scan_tracker();
        end
    endtask

    function automatic scan_row_t make_row(input int len, input logic [8*MAXB-1:0] bytes,
                                           input int typed, input int off,
                                           input kind_t kind, input int err);
        scan_row_t row;
        row.len         = len;
        row.bytes       = bytes;
        row.typed       = (typed != 0);
        row.want.offset = OFFSET_W'(off);
        row.want.kind   = kind;
        row.want.err    = err[0];
        return row;
    endfunction

    // random byte, biased toward sync and marker characters
    function automatic logic [7:0] rbyte();
        case ($urandom_range(0, 13))
            0:       return BYTE_SYNC;
            1:       return BYTE_FB;
            2:       return BYTE_F3;
            3:       return CHAR_I;
            4:       return CHAR_T;
            5:       return "R";
            6:       return "d";
            7:       return "a";
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_text(input logic [31:0] w, input int nb);
        int i;
        for (i = nb - 1; i >= 0; i--)
            scan_bytes.push_back(w[8*i +: 8]);
    endtask

    // build one random scan into scan_bytes
    task automatic build_scan();
        int         total;
        int         hdr;
        int         keep;
        int         at;
        logic [7:0] flags;
        logic [7:0] size9;
        scan_bytes.delete();
        keep = 0;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // id3v2 header, size mostly inside the scan
                flags = 8'($urandom);
                push_text("ID3", 3);
                scan_bytes.push_back(rbyte());
                scan_bytes.push_back(rbyte());
                scan_bytes.push_back(flags);
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat (4) scan_bytes.push_back(rbyte());
                    hdr   = -1;
                    total = $urandom_range(11, 30);
                end
                else
                begin
                    size9 = 8'($urandom_range(0, 12));
                    push_text({24'h000000, size9}, 4);
                    hdr   = 10 + size9 + (((flags & FOOTER_MASK) != 0) ? 10 : 0);
                    if ($urandom_range(0, 5) == 0)
                        total = $urandom_range(10, hdr);
                    else
                        total = hdr + $urandom_range(0, 14);
                end
                while (scan_bytes.size() < total) scan_bytes.push_back(rbyte());
                if (hdr >= 10 && hdr < total && $urandom_range(0, 2) == 0)
                    scan_bytes[hdr] = BYTE_SYNC;
                keep = 10;
            end
            2:
            begin
                push_text("TAG", 3);
                repeat ($urandom_range(0, 16)) scan_bytes.push_back(rbyte());
                keep = 3;
            end
            3, 4:
            begin
                repeat ($urandom_range(0, 3)) scan_bytes.push_back(rbyte());
                push_text("RIFF", 4);
                repeat ($urandom_range(0, 8)) scan_bytes.push_back(rbyte());
                if ($urandom_range(0, 3) != 0) push_text("data", 4);
                repeat ($urandom_range(0, 12)) scan_bytes.push_back(rbyte());
                keep = scan_bytes.size();
            end
            5, 6:
            begin
                repeat ($urandom_range(1, 30)) scan_bytes.push_back(rbyte());
                keep = 1;
            end
            7:
            begin
                // broken header signature
                case ($urandom_range(0, 2))
                    0:       push_text("ID3", 3);
                    1:       push_text("TAG", 3);
                    default: push_text("RIFF", 4);
                endcase
                total = $urandom_range(11, 20);
                while (scan_bytes.size() < total) scan_bytes.push_back(rbyte());
                scan_bytes[$urandom_range(0, 2)] = rbyte();
                keep = total;
            end
            default:
            begin
                repeat ($urandom_range(1, 24)) scan_bytes.push_back(rbyte());
            end
        endcase
        // drop a frame sync pattern somewhere after the header
        if (scan_bytes.size() >= keep + 2 && $urandom_range(0, 1) == 1)
        begin
            at = $urandom_range(keep, scan_bytes.size() - 2);
            scan_bytes[at]     = BYTE_SYNC;
            scan_bytes[at + 1] = ($urandom_range(0, 1) == 1) ? BYTE_FB : BYTE_F3;
        end
    endtask

    // offer one byte and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        track_byte(b, last);
    endtask

    task automatic send_scan();
        int i;
        for (i = 0; i < scan_bytes.size(); i++)
            send_byte(scan_bytes[i], i == scan_bytes.size() - 1);
    endtask

    // stop offering and let every queued start offset come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_starts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result side stall, random bursts plus long hold on request
    initial
    begin : result_stall
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = hold_req;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // compare each result with the oldest queued start offset
    always @(posedge clk)
    begin : check_results
        start_rec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_starts.size() == 0)
            begin
                $error("unexpected result: start_offset %0d start_kind %0d header_error %0d",
                       start_offset, start_kind, header_error);
                fails++;
            end
            else
            begin
                want = pending_starts.pop_front();
                if (start_offset !== want.offset)
                begin
                    $error("start_offset: expected %0d, actual %0d", want.offset, start_offset);
                    fails++;
                end
                if (start_kind !== want.kind)
                begin
                    $error("start_kind: expected %0d, actual %0d", want.kind, start_kind);
                    fails++;
                end
                if (header_error !== want.err)
                begin
                    $error("header_error: expected %0d, actual %0d", want.err, header_error);
                    fails++;
                end
            end
        end
    end

    initial
    begin : stimulus
        scan_row_t  rows [$];
        scan_row_t  row;
        logic [7:0] b;
        int         i;
        int         k;
        in_valid  <= 1'b0;
        data_byte <= 8'h00;
        last_byte <= 1'b0;
        rst_n     <= 1'b0;
        calm      = 1'b0;

        // directed scans: length, bytes, typed result or tracker
        rows.push_back(make_row(1, 8'h00, 1, 0, KIND_RAW, 0));
        rows.push_back(make_row(1, 8'hFF, 1, 0, KIND_RAW, 0));
        rows.push_back(make_row(3, {8'h00, 8'hFF, 8'hFB}, 1, 1, KIND_SYNC, 0));
        rows.push_back(make_row(3, {8'h00, 8'hFF, 8'hF3}, 1, 1, KIND_SYNC, 0));
        rows.push_back(make_row(3, {8'hFF, 8'hFF, 8'hFB}, 1, 0, KIND_RAW, 0));
        rows.push_back(make_row(3, {8'h00, 8'h00, 8'hFF}, 1, 0, KIND_RAW, 0));
        rows.push_back(make_row(11, {"TAG", {8{8'h00}}}, 1, 128, KIND_TAG, 0));
        rows.push_back(make_row(10, {"TAG", {7{8'h00}}}, 1, 0, KIND_RAW, 0));
        rows.push_back(make_row(12, {"ID3", 8'h03, 8'h00, 8'h00, {4{8'h00}}, 8'hFF, 8'hFB},
                                1, 10, KIND_ID3V2, 0));
        rows.push_back(make_row(24, {"ID3", 8'h04, 8'h00, 8'h10, {15{8'h00}},
                                     8'hFF, 8'hFB, 8'h00}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(11, {"ID3", {8{8'hFF}}}, 1, 538984595, KIND_ID3V2, 0));
        rows.push_back(make_row(14, {"ID3", 8'h03, 8'h00, 8'h00, {8{8'h00}}},
                                0, 0, KIND_RAW, 0));
        rows.push_back(make_row(12, {"ID3", 8'h03, 8'h00, 8'h00, {3{8'h00}}, 8'h05,
                                     8'h00, 8'h00}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(16, {"RIFF", {4{8'h00}}, "WAVE", "data"}, 1, 20, KIND_RIFF, 0));
        rows.push_back(make_row(12, {"RIFF", {8{8'h00}}}, 1, 0, KIND_RIFF, 1));
        rows.push_back(make_row(12, {8'h00, 8'h00, "RIFF", {6{8'h00}}}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(16, {"data", "RIFF", {8{8'h00}}}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(10, {"ID3", 8'h00, 8'hFF, 8'hFB, {4{8'h00}}}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(16, {"ID3", 8'h03, 8'h00, 8'h00, {5{8'h00}}, 8'hFF, 8'hF3,
                                     8'h00, 8'hFF, 8'hFB}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(12, {8'h00, "ID3", 8'hFF, 8'hFB, {6{8'h00}}}, 0, 0, KIND_RAW, 0));
        rows.push_back(make_row(13, {"TAG", "RIFF", {6{8'h00}}}, 0, 0, KIND_RAW, 0));

        clear_scan_tracker();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (k = 0; k < rows.size(); k++)
        begin
            row = rows[k];
            scan_bytes.delete();
            for (i = 0; i < row.len; i++)
                scan_bytes.push_back(row.bytes[8*(row.len - 1 - i) +: 8]);
            send_scan();
            if (row.typed)
                pending_starts[pending_starts.size() - 1] = row.want;
        end
        wait_drain();

        // overlong scan: sync just under the limit, bytes past the limit dropped
        for (i = 0; i < SCAN_LIMIT + 2; i++)
        begin
            if (i == 0)
                b = 8'h00;
            else if (i == SCAN_LIMIT - 2)
                b = BYTE_SYNC;
            else if (i == SCAN_LIMIT - 1)
                b = BYTE_FB;
            else if (i >= SCAN_LIMIT)
                b = 8'($urandom);
            else
                b = 8'($urandom_range(0, 8'hFE));
            send_byte(b, i == SCAN_LIMIT + 1);
        end
        wait_drain();

        // long result hold while short scans keep coming
        calm = 1'b1;
        hold_req++;
        for (i = 0; i < HOLD_SCANS; i++)
        begin
            send_byte(rbyte(), 1'b1);
            random_items++;
        end
        calm = 1'b0;
        wait_drain();

        // random scans, no idling toward the end
        while (random_items < RAND_ITEMS)
        begin
            if (random_items >= CALM_ITEMS) calm = 1'b1;
            build_scan();
            random_items += scan_bytes.size();
            send_scan();
        end
        wait_drain();

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/asof_pkg.sv
sv/audio_start_offset_finder.sv
verif/tb.sv
